// ===== src/gamepad_frame_parser_deadzone_core_assert.svh =====
`ifndef GAMEPAD_FRAME_PARSER_DEADZONE_CORE_ASSERT_SVH
`define GAMEPAD_FRAME_PARSER_DEADZONE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GFPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfpd: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GFPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfpd: assertion failed");

`endif

// ===== src/gfpd_pkg.sv =====
package gfpd_pkg;

    localparam int FRAC_BITS  = 15;
    localparam int AXIS_W     = 8;
    localparam int OUT_W      = 16;
    localparam int NUM_AXES   = 4;
    localparam int IDX_W      = $clog2(NUM_AXES);
    localparam int DZ_W       = 7;
    localparam int SUM_W      = 7;

    localparam logic [AXIS_W-1:0] HEADER_BYTE = 8'h80;
    localparam logic [AXIS_W-1:0] AXIS_SPAN   = 8'd128;
    localparam logic [DZ_W-1:0]   DZ_RESET    = 7'd10;

    // Byte position inside a frame: 0 hunts for the header, 7 is the checksum.
    localparam int POS_W      = 3;
    localparam int FRAME_BODY = 7;
    localparam int NUM_PAY    = FRAME_BODY - 1;
    localparam logic [POS_W-1:0] POS_HUNT  = 3'd0;
    localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_BODY);

    // Radix-4 restoring divider: two quotient bits per cycle.
    localparam int DIV_STEPS = (AXIS_W + FRAC_BITS + 1) / 2;
    localparam int QUO_W     = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [OUT_W-1:0]                    buttons;
        logic [NUM_AXES-1:0][AXIS_W-1:0]     axes;
    } frame_t;

endpackage

// ===== src/gfpd_front.sv =====
module gfpd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             push_valid,
    input  logic             push_ready,
    output gfpd_pkg::frame_t push_data
);
    import gfpd_pkg::*;

    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [NUM_PAY-1:0][AXIS_W-1:0] pay_reg;
    logic                           accept;
    logic                           is_payload;

    // Only the checksum byte needs room in the queue.
    assign in_ready   = !(pos_reg == POS_CHECK && !push_ready);
    assign accept     = in_valid && in_ready;
    assign is_payload = (pos_reg != POS_HUNT) && (pos_reg != POS_CHECK);

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == HEADER_BYTE)
                begin
                    pos_next = POS_FIRST;
                    sum_next = HEADER_BYTE[SUM_W-1:0];
                end
            end
            else if (pos_reg == POS_CHECK)
            begin
                pos_next = POS_HUNT;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                sum_next = sum_reg + rx_byte[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Payload bytes shift in, so the first one ends up in slot 0.
    always_ff @(posedge clk)
    begin
        if (accept && is_payload)
        begin
            pay_reg <= {rx_byte, pay_reg[NUM_PAY-1:1]};
        end
    end

    // A checksum with bit 7 set never matches the zero-extended sum.
    assign push_valid = accept && (pos_reg == POS_CHECK) && (rx_byte == {1'b0, sum_reg});

    always_comb
    begin
        push_data.buttons = {pay_reg[0], pay_reg[1]};
        for (int i = 0; i < NUM_AXES; i++)
        begin
            push_data.axes[i] = pay_reg[i + 2];
        end
    end

endmodule

// ===== src/gfpd_fifo.sv =====
`include "gamepad_frame_parser_deadzone_core_assert.svh"

module gfpd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  gfpd_pkg::frame_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output gfpd_pkg::frame_t pop_data
);
    import gfpd_pkg::*;

    frame_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    `GFPD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `GFPD_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `GFPD_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== src/gfpd_back.sv =====
`include "gamepad_frame_parser_deadzone_core_assert.svh"

module gfpd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [6:0]              deadzone,
    input  logic                    frame_valid,
    output logic                    frame_ready,
    input  gfpd_pkg::frame_t        frame_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             buttons,
    output logic signed [15:0]      left_x,
    output logic signed [15:0]      left_y,
    output logic signed [15:0]      right_x,
    output logic signed [15:0]      right_y
);
    import gfpd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    localparam logic [QUO_W-1:0] SAT_NEG = QUO_W'(32768);
    localparam logic [QUO_W-1:0] SAT_POS = QUO_W'(32767);

    // Dead zone on one axis byte; returns {sign, magnitude}.
    function automatic logic [AXIS_W:0] axis_prep(input logic [AXIS_W-1:0] raw,
                                                  input logic [DZ_W-1:0] dz);
        logic signed [AXIS_W:0] s;
        logic signed [AXIS_W:0] d;
        logic signed [AXIS_W:0] a;
        logic        [AXIS_W:0] mag;
        s = {raw[AXIS_W-1], raw};
        d = {2'b00, dz};
        if (s < d && s > -d)
        begin
            a = '0;
        end
        else if (s > 0)
        begin
            a = s - d;
        end
        else
        begin
            a = s + d;
        end
        mag = a[AXIS_W] ? -a : a;
        return {a[AXIS_W], mag[AXIS_W-1:0]};
    endfunction

    function automatic logic [OUT_W-1:0] saturate(input logic [QUO_W-1:0] q,
                                                  input logic neg);
        logic [OUT_W-1:0] lo;
        lo = q[OUT_W-1:0];
        if (neg)
        begin
            return (q >= SAT_NEG) ? 16'h8000 : OUT_W'(0) - lo;
        end
        return (q >= SAT_POS) ? 16'h7fff : lo;
    endfunction

    back_state_t                    st_reg, st_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic                           out_valid_reg, out_valid_next;

    logic [AXIS_W-1:0]              rem_reg, rem_c;
    logic [QUO_W-1:0]               dvd_reg, dvd_c;
    logic [QUO_W-1:0]               quo_reg, quo_c;
    logic                           neg_reg;
    logic [OUT_W-1:0]               btn_reg;
    logic [NUM_AXES-1:0][AXIS_W-1:0] raw_reg;
    logic [NUM_AXES-1:0][OUT_W-1:0]  res_reg;
    logic [OUT_W-1:0]               out_btn_reg;
    logic [NUM_AXES-1:0][OUT_W-1:0]  out_axis_reg;

    logic [AXIS_W-1:0]              divisor;
    logic [AXIS_W:0]                trial;
    logic [AXIS_W-1:0]              prep_raw;
    logic [AXIS_W:0]                prep;
    logic [QUO_W-1:0]               dvd_init;
    logic                           last_step;
    logic                           last_axis;
    logic                           take_frame;
    logic                           load_out;

    assign divisor     = AXIS_SPAN - {1'b0, deadzone};
    assign last_step   = step_reg == STEP_W'(DIV_STEPS - 1);
    assign last_axis   = idx_reg == IDX_W'(NUM_AXES - 1);
    assign frame_ready = st_reg == ST_IDLE;
    assign take_frame  = frame_valid && frame_ready;
    assign load_out    = (st_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // The next axis is set up while the current one finishes its last step.
    assign prep_raw = (st_reg == ST_IDLE) ? frame_data.axes[0] : raw_reg[idx_reg + 1'b1];
    assign prep     = axis_prep(prep_raw, deadzone);
    assign dvd_init = QUO_W'(prep[AXIS_W-1:0]) << FRAC_BITS;

    // Two restoring steps per cycle; the remainder stays below the divisor while the deadzone is unchanged.
    always_comb
    begin
        rem_c = rem_reg;
        dvd_c = dvd_reg;
        quo_c = quo_reg;
        trial = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial = {rem_c, dvd_c[QUO_W-1]};
            dvd_c = {dvd_c[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_c = AXIS_W'(trial - {1'b0, divisor});
                quo_c = {quo_c[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_c = trial[AXIS_W-1:0];
                quo_c = {quo_c[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        st_next        = st_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (st_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    st_next   = ST_DIV;
                    idx_next  = '0;
                    step_next = '0;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    step_next = '0;
                    if (last_axis)
                    begin
                        st_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    st_next        = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_frame)
        begin
            btn_reg <= frame_data.buttons;
            raw_reg <= frame_data.axes;
            rem_reg <= '0;
            quo_reg <= '0;
            dvd_reg <= dvd_init;
            neg_reg <= prep[AXIS_W];
        end
        else if (st_reg == ST_DIV)
        begin
            if (last_step)
            begin
                res_reg[idx_reg] <= saturate(quo_c, neg_reg);
                rem_reg          <= '0;
                quo_reg          <= '0;
                dvd_reg          <= dvd_init;
                neg_reg          <= prep[AXIS_W];
            end
            else
            begin
                rem_reg <= rem_c;
                quo_reg <= quo_c;
                dvd_reg <= dvd_c;
            end
        end
        if (load_out)
        begin
            out_btn_reg  <= btn_reg;
            out_axis_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign buttons   = out_btn_reg;
    assign left_x    = out_axis_reg[0];
    assign left_y    = out_axis_reg[1];
    assign right_x   = out_axis_reg[2];
    assign right_y   = out_axis_reg[3];

    `GFPD_ASSERT_IMPL(a_rem_below_div, st_reg == ST_DIV, rem_reg < divisor)
    `GFPD_ASSERT_IMPL(a_done_after_last, st_reg == ST_DONE, last_axis)
    `GFPD_ASSERT_NEXT(a_load_shows, load_out, out_valid_reg && st_reg == ST_IDLE)

endmodule

// ===== src/gamepad_frame_parser_deadzone_core.sv =====
// Byte input takes one item per cycle; the checksum byte waits only when the
// two-frame queue between parser and arithmetic is full.
// A good frame reaches the output after its four axes pass, in turn, through
// one shared radix-4 divider. The arithmetic takes a new frame only once the
// last one is loaded to the output; the queue holds frames in the meantime.
// Reset (async, active low) returns to header hunt, empties the queue and
// loads deadzone 10; the frame byte registers are not cleared.
module gamepad_frame_parser_deadzone_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          deadzone,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         buttons,
    output logic signed [15:0]  left_x,
    output logic signed [15:0]  left_y,
    output logic signed [15:0]  right_x,
    output logic signed [15:0]  right_y
);
    import gfpd_pkg::*;

    logic [DZ_W-1:0] deadzone_reg;
    logic            push_valid, push_ready;
    frame_t          push_data;
    logic            frame_valid, frame_ready;
    frame_t          frame_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= DZ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            deadzone_reg <= deadzone;
        end
    end

    gfpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    gfpd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (frame_valid),
        .pop_ready  (frame_ready),
        .pop_data   (frame_data)
    );

    gfpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .deadzone    (deadzone_reg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .buttons     (buttons),
        .left_x      (left_x),
        .left_y      (left_y),
        .right_x     (right_x),
        .right_y     (right_y)
    );

endmodule
